// ----- rtl/code_breakpoint_slot_manager_assert.svh -----
// ----------------------------------------------------------------------------
// Breakpoint slot manager assertion macros
// Shorthand for the concurrent checks used in the slot manager RTL.
// ----------------------------------------------------------------------------
`ifndef CODE_BREAKPOINT_SLOT_MANAGER_ASSERT_SVH
`define CODE_BREAKPOINT_SLOT_MANAGER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define CBSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define CBSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cbsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Breakpoint slot manager package
// Transaction types, request and status codes, and controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbsm_pkg;

  // Request type codes.
  localparam logic [1:0] REQ_REMOVE = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_RSVD   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNALIGNED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Half bits of a slot.
  localparam logic [1:0] HALF_LOW  = 2'b01;
  localparam logic [1:0] HALF_HIGH = 2'b10;

  // Width of a slot index carried between controller and datapath.
  localparam int SLOT_IDX_W = 4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        write_valid;
    logic [2:0]  slot;
    logic [31:0] comparator_word;
    logic        last;
  } rsp_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t               op;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  last;
  } cmd_t;

  typedef struct packed {
    logic clear_req;
  } stat_t;

endpackage

// ----- rtl/cbsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Breakpoint slot manager controller
// Sequences request capture, table update and the clear-all sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbsm_ctrl #(
  parameter int NUM_SLOTS = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cbsm_pkg::stat_t stat,
  output cbsm_pkg::cmd_t  cmd,
  output logic           busy
);
  import cbsm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CLEAR
  } state_t;

  localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(NUM_SLOTS - 1);

  state_t                state;
  state_t                state_next;
  logic [SLOT_IDX_W-1:0] count;
  logic [SLOT_IDX_W-1:0] count_next;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd.op     = CMD_NONE;
    cmd.idx    = '0;
    cmd.last   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = CMD_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.clear_req) begin
          // The first slot is cleared here; the sweep covers the rest.
          cmd.op   = CMD_CLEAR;
          cmd.idx  = '0;
          cmd.last = (LAST_IDX == '0);
          if (LAST_IDX == '0) begin
            state_next = S_IDLE;
          end else begin
            count_next = SLOT_IDX_W'(1);
            state_next = S_CLEAR;
          end
        end else begin
          cmd.op     = CMD_EXEC;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd.op   = CMD_CLEAR;
        cmd.idx  = count;
        cmd.last = (count == LAST_IDX);
        if (count == LAST_IDX) begin
          state_next = S_IDLE;
        end else begin
          count_next = count + SLOT_IDX_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ----- rtl/cbsm_datapath.sv -----
// ----------------------------------------------------------------------------
// Breakpoint slot manager datapath
// Slot table, slot search, half-bit update and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbsm_datapath #(
  parameter int NUM_SLOTS = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  cbsm_pkg::cmd_t  cmd,
  input  cbsm_pkg::req_t  request,
  output cbsm_pkg::stat_t stat,
  output logic            strobe,
  output cbsm_pkg::rsp_t  result
);
  import cbsm_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  req_t        req;
  logic [29:0] slot_addr   [NUM_SLOTS];
  logic [1:0]  slot_halves [NUM_SLOTS];

  logic [29:0]          waddr;
  logic [1:0]           half;
  logic                 insert;
  logic [NUM_SLOTS-1:0] hit;
  logic                 found;
  logic [IDX_W-1:0]     id;
  logic [1:0]           cur_h;
  logic [1:0]           new_h;
  logic                 exec_write;
  rsp_t                 exec_rsp;
  rsp_t                 clear_rsp;
  logic [IDX_W-1:0]     clr_idx;

  assign stat.clear_req = (req.req_type == REQ_CLEAR);

  assign waddr   = req.address[31:2];
  assign half    = req.address[1] ? HALF_HIGH : HALF_LOW;
  assign insert  = (req.req_type == REQ_INSERT);
  assign clr_idx = cmd.idx[IDX_W-1:0];

  // A slot qualifies on an address match, or on insert when it is unused.
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit[i] = (slot_addr[i] == waddr) || (insert && (slot_halves[i] == 2'b00));
    end
  end

  // The lowest qualifying slot wins.
  always_comb begin
    found = 1'b0;
    id    = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        id    = IDX_W'(i);
      end
    end
  end

  assign cur_h = slot_halves[id];
  assign new_h = insert ? (cur_h | half) : (cur_h & ~half);

  always_comb begin
    exec_write               = 1'b0;
    exec_rsp.status          = ST_OK;
    exec_rsp.write_valid     = 1'b0;
    exec_rsp.slot            = '0;
    exec_rsp.comparator_word = '0;
    exec_rsp.last            = 1'b1;
    if (req.req_type == REQ_RSVD) begin
      exec_write = 1'b0;
    end else if (req.address[0]) begin
      exec_rsp.status = ST_UNALIGNED;
    end else if (!found) begin
      exec_rsp.status = insert ? ST_FULL : ST_OK;
    end else begin
      exec_write           = 1'b1;
      exec_rsp.write_valid = 1'b1;
      exec_rsp.slot        = 3'(id);
      if (new_h != 2'b00) begin
        exec_rsp.comparator_word = {new_h, 1'b0, waddr[26:0], 1'b0, 1'b1};
      end
    end
  end

  always_comb begin
    clear_rsp.status          = ST_OK;
    clear_rsp.write_valid     = 1'b1;
    clear_rsp.slot            = cmd.idx[2:0];
    clear_rsp.comparator_word = '0;
    clear_rsp.last            = cmd.last;
  end

  // Slot table and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_addr[i]   <= '0;
        slot_halves[i] <= '0;
      end
    end else begin
      case (cmd.op)
        CMD_EXEC: begin
          strobe <= 1'b1;
          if (exec_write) begin
            slot_addr[id]   <= waddr;
            slot_halves[id] <= new_h;
          end
        end
        CMD_CLEAR: begin
          strobe               <= 1'b1;
          slot_halves[clr_idx] <= 2'b00;
        end
        default: begin
          strobe <= 1'b0;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD:  req    <= request;
      CMD_EXEC:  result <= exec_rsp;
      CMD_CLEAR: result <= clear_rsp;
      default:   req    <= req;
    endcase
  end

endmodule

// ----- rtl/code_breakpoint_slot_manager.sv -----
// ----------------------------------------------------------------------------
// Code breakpoint slot manager
// Allocates and releases breakpoint comparator slots and issues the writes.
// ----------------------------------------------------------------------------
// Usage: a request transaction is accepted on the rising edge where start is
// high and busy is low. The request carries a type (remove, insert or clear
// all) and a halfword address. Results leave on the result port, each valid
// for exactly one cycle while strobe is high; the receiver cannot stall, so
// it must take every result on the cycle it appears.
// Insert, remove, rejected and reserved requests produce one result. busy is
// high while the request is in the block, and a new request may be accepted
// in the cycle the result is shown. A clear-all request produces NUM_SLOTS
// results on consecutive cycles, with last set only on the final one; busy
// stays high until that final result is shown. The controller sets this
// order: it captures the request, then runs the slot search with its
// read-modify-write, or the clear sweep one slot at a time.
// Reset clears every slot's word address and half bits and returns the
// controller to idle, so the block accepts a request at the first rising
// edge with rst low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "code_breakpoint_slot_manager_assert.svh"

module code_breakpoint_slot_manager #(
  parameter int NUM_SLOTS = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  cbsm_pkg::req_t request,
  output logic           strobe,
  output cbsm_pkg::rsp_t result
);
  import cbsm_pkg::*;

  // Commands from the controller into the datapath, status back.
  cmd_t  cmd;
  stat_t stat;

  // The controller decides when a request is captured, when the search
  // and update run, and which slot the clear sweep touches next.
  cbsm_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the slot table and registers every result.
  cbsm_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .stat    (stat),
    .strobe  (strobe),
    .result  (result)
  );

  // An accepted transaction keeps the block busy in the following cycle.
  `CBSM_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  // The clear sweep emits its results back to back.
  `CBSM_ASSERT_NXT(a_sweep_cont, strobe && !result.last, strobe, "gap inside result burst")
  // The final result of a request is shown while the block is idle again.
  `CBSM_ASSERT_IMP(a_last_idle, strobe && result.last, !busy, "busy after final result")
  // Rejected requests never issue a comparator write.
  `CBSM_ASSERT_IMP(a_reject_nowr, strobe && (result.status != ST_OK), !result.write_valid,
                   "rejected request issued a write")

endmodule

// ----- tb/code_breakpoint_slot_manager_tb.sv -----
// ----------------------------------------------------------------------------
// Breakpoint slot manager testbench
// Drives insert, remove and clear-all requests into the slot manager and checks
// every comparator write against an in-bench model of the slot table. A short
// directed part covers the special cases; random traffic follows, built mostly
// from a small pool of word addresses so that slots match, fill and free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module code_breakpoint_slot_manager_tb;
  import cbsm_pkg::*;

  localparam int NUM_SLOTS      = 6;
  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 6;
  // No correct run goes this long without a request or a result moving: the
  // sender gaps and the clear sweeps are all much shorter.
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles to let pass after the last expected result before the verdict.
  localparam int DRAIN_CYCLES   = 12;
  localparam int POOL_SIZE      = 8;

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  req_t   request;
  logic   strobe;
  rsp_t   result;

  // Model of the comparator table, updated when a request is accepted.
  logic [29:0] bp_word_addr [NUM_SLOTS];
  logic [1:0]  bp_halves    [NUM_SLOTS];

  // Comparator writes predicted but not yet seen on the result port.
  rsp_t        expected_writes [$];

  // Word addresses that random traffic draws from.
  logic [29:0] addr_pool [POOL_SIZE];

  int          mismatch_count;
  int          quiet_cycles;

  code_breakpoint_slot_manager #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Works out the comparator writes that one accepted request causes and
  // updates the table model the same way the block should.
  task automatic predict_slot_update(input req_t req);
    rsp_t        wr;
    int          hit;
    logic [29:0] waddr;
    logic [1:0]  half;
    logic        is_insert;
    wr           = '0;
    wr.status    = ST_OK;
    wr.last      = 1'b1;
    hit          = -1;
    waddr        = req.address[31:2];
    half         = req.address[1] ? HALF_HIGH : HALF_LOW;
    is_insert    = (req.req_type == REQ_INSERT);
    case (req.req_type)
      REQ_CLEAR: begin
        // One zero write per slot; stored word addresses stay as they are.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          bp_halves[i]   = '0;
          wr.write_valid = 1'b1;
          wr.slot        = i[2:0];
          wr.last        = (i == NUM_SLOTS - 1);
          expected_writes.push_back(wr);
        end
      end
      REQ_RSVD: begin
        expected_writes.push_back(wr);
      end
      default: begin
        if (req.address[0]) begin
          wr.status = ST_UNALIGNED;
        end else begin
          // First slot with the same word address, or on insert the first
          // slot with no half in use, whichever comes first.
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (hit < 0 && (bp_word_addr[i] == waddr ||
                            (is_insert && bp_halves[i] == '0))) begin
              hit = i;
            end
          end
          if (hit < 0) begin
            wr.status = is_insert ? ST_FULL : ST_OK;
          end else begin
            bp_word_addr[hit] = waddr;
            if (is_insert) begin
              bp_halves[hit] = bp_halves[hit] | half;
            end else begin
              bp_halves[hit] = bp_halves[hit] & ~half;
            end
            wr.write_valid = 1'b1;
            wr.slot        = hit[2:0];
            // Word address at bits 28:2, enable at bit 0, halves at 31:30.
            if (bp_halves[hit] != '0) begin
              wr.comparator_word = {bp_halves[hit], 1'b0, waddr[26:0], 1'b0, 1'b1};
            end
          end
        end
        expected_writes.push_back(wr);
      end
    endcase
  endtask

  // Checks results, predicts accepted requests and runs the watchdog. Both the
  // check and the prediction read values sampled at the same rising edge, so
  // the outcome does not hang on process order.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        bp_word_addr[i] = '0;
        bp_halves[i]    = '0;
      end
      expected_writes.delete();
      quiet_cycles = 0;
    end else begin
      if (strobe !== 1'b0) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", result));
        end else begin
          if (result.status !== expected_writes[0].status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result.status, expected_writes[0].status));
          if (result.write_valid !== expected_writes[0].write_valid)
            report_mismatch($sformatf("write_valid %0b, expected %0b",
                                      result.write_valid,
                                      expected_writes[0].write_valid));
          if (result.slot !== expected_writes[0].slot)
            report_mismatch($sformatf("slot %0d, expected %0d",
                                      result.slot, expected_writes[0].slot));
          if (result.comparator_word !== expected_writes[0].comparator_word)
            report_mismatch($sformatf("comparator_word %h, expected %h",
                                      result.comparator_word,
                                      expected_writes[0].comparator_word));
          if (result.last !== expected_writes[0].last)
            report_mismatch($sformatf("last %0b, expected %0b",
                                      result.last, expected_writes[0].last));
          void'(expected_writes.pop_front());
        end
      end
      if (start && !busy) begin
        predict_slot_update(request);
      end
      if ((strobe !== 1'b0) || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles",
                 $realtime, WATCHDOG_LIMIT);
        $display("code_breakpoint_slot_manager_tb: FAIL");
        $finish;
      end
    end
  end

  // Presents one request from the falling edge on and holds it until the
  // block takes it. start stays high on return so back-to-back requests keep
  // it high without a glitch.
  task automatic issue_request(input logic [1:0] kind, input logic [31:0] addr);
    @(negedge clk);
    start            <= 1'b1;
    request.req_type <= kind;
    request.address  <= addr;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_writes_done();
    @(negedge clk);
    start <= 1'b0;
    while (expected_writes.size() != 0) @(negedge clk);
  endtask

  task automatic test_insert_remove();
    issue_request(REQ_INSERT, 32'h0000_0000);
    issue_request(REQ_INSERT, 32'h0000_0002);
    issue_request(REQ_REMOVE, 32'h0000_0000);
    issue_request(REQ_REMOVE, 32'h0000_0002);
    // No slot holds this word, so the remove succeeds without a write.
    issue_request(REQ_REMOVE, 32'h1234_5678);
  endtask

  task automatic test_rejected_requests();
    issue_request(REQ_INSERT, 32'h0000_0001);
    issue_request(REQ_REMOVE, 32'hFFFF_FFFF);
    issue_request(REQ_RSVD,   32'hFFFF_FFFF);
    issue_request(REQ_RSVD,   32'h0000_0000);
  endtask

  task automatic test_table_full();
    // Words that differ only in bits 31:29 must take separate slots.
    issue_request(REQ_INSERT, 32'hFFFF_FFFE);
    issue_request(REQ_INSERT, 32'h2000_0000);
    issue_request(REQ_INSERT, 32'h0000_1000);
    issue_request(REQ_INSERT, 32'h0000_1004);
    issue_request(REQ_INSERT, 32'h8000_0002);
    issue_request(REQ_INSERT, 32'hAAAA_AAA8);
    issue_request(REQ_INSERT, 32'h4000_0000);
    // Full table, but a word already held still takes its other half.
    issue_request(REQ_INSERT, 32'h0000_1002);
    issue_request(REQ_REMOVE, 32'h5555_5554);
  endtask

  task automatic test_clear_all();
    issue_request(REQ_CLEAR,  32'hFFFF_FFFF);
    // A cleared slot keeps its word, so this remove writes zero to it.
    issue_request(REQ_REMOVE, 32'h0000_1000);
    issue_request(REQ_INSERT, 32'h5555_5554);
    issue_request(REQ_CLEAR,  32'h0000_0000);
  endtask

  // Random requests, mostly inserts and removes on a small pool of words so
  // that halves pair up, slots get reused and the table fills.
  task automatic test_random_traffic(input int count, input bit with_gaps);
    int          pick;
    logic [1:0]  kind;
    logic [31:0] addr;
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = 30'($urandom());
    for (int n = 0; n < count; n++) begin
      if (with_gaps && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 4));
      pick = $urandom_range(0, 99);
      addr = {addr_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom_range(0, 1) == 1, 1'b0};
      if (pick < 45) begin
        kind = REQ_INSERT;
      end else if (pick < 85) begin
        kind = REQ_REMOVE;
      end else if (pick < 89) begin
        kind = REQ_CLEAR;
        addr = $urandom();
      end else if (pick < 92) begin
        kind = REQ_RSVD;
        addr = $urandom();
      end else if (pick < 96) begin
        kind = $urandom_range(0, 1) ? REQ_INSERT : REQ_REMOVE;
        addr = $urandom() | 32'h1;
      end else begin
        kind = $urandom_range(0, 1) ? REQ_INSERT : REQ_REMOVE;
        addr = $urandom() & ~32'h1;
      end
      issue_request(kind, addr);
    end
  endtask

  // The sender holds off until every comparator write has come back.
  task automatic test_drain_pause();
    wait_for_writes_done();
  endtask

  initial begin
    mismatch_count = 0;
    rst            = 1'b1;
    start          = 1'b0;
    request        = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_insert_remove();
    test_rejected_requests();
    test_table_full();
    test_clear_all();
    test_random_traffic(200, 1'b1);
    test_drain_pause();
    test_random_traffic(170, 1'b1);
    test_drain_pause();
    // Closing stretch runs back to back with no sender gaps.
    test_random_traffic(80, 1'b0);

    wait_for_writes_done();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("code_breakpoint_slot_manager_tb: PASS");
    end else begin
      $display("code_breakpoint_slot_manager_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cbsm_pkg.sv
rtl/cbsm_ctrl.sv
rtl/cbsm_datapath.sv
rtl/code_breakpoint_slot_manager.sv
tb/code_breakpoint_slot_manager_tb.sv
